// ----- hw/rtl/pmq_pkg.sv -----
package pmq_pkg;

    typedef logic [4:0] t_op;

    localparam t_op OP_ABS    = 5'd0;
    localparam t_op OP_DIV    = 5'd1;
    localparam t_op OP_DIVS   = 5'd2;
    localparam t_op OP_DOZ    = 5'd3;
    localparam t_op OP_DOZI   = 5'd4;
    localparam t_op OP_MASKG  = 5'd5;
    localparam t_op OP_MASKIR = 5'd6;
    localparam t_op OP_MUL    = 5'd7;
    localparam t_op OP_NABS   = 5'd8;
    localparam t_op OP_RLMI   = 5'd9;
    localparam t_op OP_RRIB   = 5'd10;
    localparam t_op OP_SLE    = 5'd11;
    localparam t_op OP_SLEQ   = 5'd12;
    localparam t_op OP_SLIQ   = 5'd13;
    localparam t_op OP_SLLIQ  = 5'd14;
    localparam t_op OP_SLLQ   = 5'd15;
    localparam t_op OP_SLQ    = 5'd16;
    localparam t_op OP_SRAIQ  = 5'd17;
    localparam t_op OP_SRAQ   = 5'd18;
    localparam t_op OP_SRE    = 5'd19;
    localparam t_op OP_SREA   = 5'd20;
    localparam t_op OP_SREQ   = 5'd21;
    localparam t_op OP_SRIQ   = 5'd22;
    localparam t_op OP_SRLIQ  = 5'd23;
    localparam t_op OP_SRLQ   = 5'd24;
    localparam t_op OP_SRQ    = 5'd25;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 72;
    localparam int Q_DEPTH    = 2;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        t_op          op;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  s;
        logic [4:0]   imm;
        logic [4:0]   mb;
        logic [4:0]   me;
        logic [15:0]  simm;
        logic         rec;
        logic         oe;
    } t_item;

    typedef struct packed {
        logic [31:0] res;
        logic        to_a;
        logic        wr;
        logic [31:0] crv;
        logic [31:0] mq;
        logic        so;
        logic        ov;
        logic        ca;
    } t_res;

endpackage

// ----- hw/rtl/pmq_front.sv -----
module pmq_front
    import pmq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [4:0]            s_axis_tuser,
    output logic                  o_push,
    output t_item                 o_item,
    input  logic                  i_q_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign s_axis_tready = !r_valid || i_q_ready;
    assign o_push        = r_valid;
    assign o_item        = r_item;

    always_comb begin
        n_item.op   = s_axis_tuser;
        n_item.a    = s_axis_tdata[31:0];
        n_item.b    = s_axis_tdata[63:32];
        n_item.s    = s_axis_tdata[95:64];
        n_item.imm  = s_axis_tdata[100:96];
        n_item.mb   = s_axis_tdata[105:101];
        n_item.me   = s_axis_tdata[110:106];
        n_item.simm = s_axis_tdata[126:111];
        n_item.rec  = s_axis_tdata[127];
        n_item.oe   = s_axis_tdata[128];
        if (s_axis_tuser == OP_MUL) begin
            n_item.kind = K_MUL;
        end else if (s_axis_tuser == OP_DIV || s_axis_tuser == OP_DIVS) begin
            n_item.kind = K_DIV;
        end else begin
            n_item.kind = K_SIMPLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- hw/rtl/pmq_queue.sv -----
module pmq_queue
    import pmq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PW = $clog2(Q_DEPTH);

    t_item         r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_ready = (r_cnt != (PW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign wr_en   = i_push && o_ready;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(wr_en) - (PW+1)'(rd_en);
        end
        if (wr_en) begin
            r_mem[r_wp] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not follow a push");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !rd_en)
        else $error("read from empty queue");
`endif

endmodule

// ----- hw/rtl/pmq_back.sv -----
module pmq_back
    import pmq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [31:0]   r_mq;
    logic          r_so, r_ov, r_ca;
    t_item         r_item;
    logic [63:0]   r_prod;
    logic [63:0]   r_dq;
    logic [31:0]   r_rem;
    logic [31:0]   r_dvs;
    logic          r_sa;
    logic [5:0]    r_cnt;
    logic          r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic          r_odest;

    logic          out_free;
    logic          ld;
    t_res          sres, fres, ures;
    logic [3:0]    cond;
    logic [63:0]   dvd;
    logic [32:0]   trial;
    logic          ge;
    logic [63:0]   q_s;
    logic [31:0]   rem_s;
    logic          q_neg;
    logic          div_ovf;
    logic          mul_ovf;

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        return (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
        return (v >> n) | (v << (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] span(input logic [4:0] mb, input logic [4:0] me);
        logic [31:0] m1;
        logic [31:0] m2;
        m1 = 32'hFFFF_FFFF >> mb;
        m2 = 32'hFFFF_FFFF << (5'd31 - me);
        return (mb <= me) ? (m1 & m2) : (m1 | m2);
    endfunction

    function automatic t_res exec_simple(input t_item it, input logic [31:0] mq,
                                         input logic so, input logic ov, input logic ca);
        t_res        r;
        logic [4:0]  sh;
        logic        ext;
        logic [31:0] m;
        logic [31:0] rt;
        logic [31:0] simm;
        logic        ovf;
        logic        use_oe;
        sh     = it.b[4:0];
        ext    = it.b[5];
        simm   = {{16{it.simm[15]}}, it.simm};
        r.res  = '0;
        r.to_a = 1'b1;
        r.wr   = it.rec;
        r.mq   = mq;
        r.ca   = ca;
        ovf    = 1'b0;
        use_oe = 1'b0;
        m      = '0;
        rt     = '0;
        unique case (it.op)
            OP_ABS: begin
                r.to_a = 1'b0;
                use_oe = 1'b1;
                ovf    = (it.a == 32'h8000_0000);
                r.res  = it.a[31] ? (32'd0 - it.a) : it.a;
            end
            OP_DOZ: begin
                r.to_a = 1'b0;
                use_oe = 1'b1;
                r.res  = ($signed(it.a) < $signed(it.b)) ? (it.b - it.a) : 32'd0;
                ovf    = r.res[31];
            end
            OP_DOZI: begin
                r.to_a = 1'b0;
                r.wr   = 1'b0;
                r.res  = ($signed(it.a) > $signed(simm)) ? 32'd0 : (simm - it.a);
            end
            OP_MASKG: begin
                if (it.s[4:0] <= sh) begin
                    r.res = span(it.s[4:0], sh);
                end else if (it.s[4:0] == sh + 5'd1) begin
                    r.res = 32'hFFFF_FFFF;
                end else begin
                    r.res = ~span(sh + 5'd1, it.s[4:0] - 5'd1);
                end
            end
            OP_MASKIR: r.res = (it.a & ~it.b) | (it.s & it.b);
            OP_NABS: begin
                r.to_a = 1'b0;
                use_oe = 1'b1;
                r.res  = it.a[31] ? it.a : (32'd0 - it.a);
            end
            OP_RLMI: begin
                m     = span(it.mb, it.me);
                r.res = (rotl(it.s, sh) & m) | (it.a & ~m);
            end
            OP_RRIB: begin
                m     = 32'h8000_0000 >> sh;
                r.res = it.s[31] ? (it.a | m) : (it.a & ~m);
            end
            OP_SLE, OP_SLIQ: begin
                if (it.op == OP_SLIQ) begin
                    sh = it.imm;
                end
                r.res = it.s << sh;
                r.mq  = rotl(it.s, sh);
            end
            OP_SLEQ, OP_SLLIQ: begin
                if (it.op == OP_SLLIQ) begin
                    sh = it.imm;
                end
                rt    = rotl(it.s, sh);
                m     = 32'hFFFF_FFFF << sh;
                r.res = (rt & m) | (mq & ~m);
                r.mq  = rt;
            end
            OP_SLLQ: begin
                m     = 32'hFFFF_FFFF << sh;
                r.res = ext ? (mq & m) : ((it.s << sh) | (mq & ~m));
            end
            OP_SLQ: begin
                r.res = ext ? 32'd0 : (it.s << sh);
                r.mq  = rotl(it.s, sh);
            end
            OP_SRAIQ: begin
                m     = ~(32'hFFFF_FFFF << it.imm);
                r.res = asr(it.s, it.imm);
                r.ca  = it.s[31] && ((it.s & m) != '0);
                r.mq  = rotr(it.s, it.imm);
            end
            OP_SRAQ: begin
                m     = ext ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << sh);
                r.res = asr(it.s, ext ? 5'd31 : sh);
                r.ca  = it.s[31] && ((it.s & m) != '0);
                r.mq  = rotr(it.s, sh);
            end
            OP_SRE, OP_SRIQ: begin
                if (it.op == OP_SRIQ) begin
                    sh = it.imm;
                end
                r.res = it.s >> sh;
                r.mq  = rotr(it.s, sh);
            end
            OP_SREA: begin
                rt    = rotr(it.s, sh);
                m     = 32'hFFFF_FFFF >> sh;
                r.res = asr(it.s, sh);
                r.ca  = it.s[31] && ((rt & ~m) != '0);
                r.mq  = rt;
            end
            OP_SREQ: begin
                m     = 32'hFFFF_FFFF >> sh;
                r.res = (it.s >> sh) | (mq & ~m);
                r.mq  = rotr(it.s, sh);
            end
            OP_SRLIQ: begin
                rt    = rotr(it.s, it.imm);
                m     = 32'hFFFF_FFFF >> it.imm;
                r.res = (rt & m) | (mq & ~m);
                r.mq  = rt;
            end
            OP_SRLQ: begin
                rt    = rotr(it.s, sh);
                m     = 32'hFFFF_FFFF >> sh;
                r.res = ext ? (mq & m) : ((rt & m) | (mq & ~m));
            end
            OP_SRQ: begin
                r.res = ext ? 32'd0 : (it.s >> sh);
                r.mq  = rotr(it.s, sh);
            end
            default: begin
                r.to_a = 1'b0;
                r.wr   = 1'b0;
            end
        endcase
        r.crv = r.res;
        r.ov  = (use_oe && it.oe) ? ovf : ov;
        r.so  = so | (use_oe && it.oe && ovf);
        return r;
    endfunction

    assign out_free = !r_ovalid || m_axis_tready;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid &&
                      ((i_q_item.kind != K_SIMPLE) || out_free);

    // dividend (a:MQ for div, sign-extended a for divs) and divide trial compare
    assign dvd   = (i_q_item.op == OP_DIV) ? {i_q_item.a, r_mq}
                                           : {{32{i_q_item.a[31]}}, i_q_item.a};
    assign trial = {r_rem, r_dq[63]};
    assign ge    = trial >= {1'b0, r_dvs};

    assign q_neg   = r_sa ^ r_item.b[31];
    assign q_s     = q_neg ? (64'd0 - r_dq) : r_dq;
    assign rem_s   = r_sa ? (32'd0 - r_rem) : r_rem;
    assign div_ovf = (q_s[63:31] != {33{q_s[31]}});
    assign mul_ovf = (r_prod[63:31] != {33{r_prod[31]}});

    always_comb begin
        logic ovf;
        ovf      = 1'b0;
        fres     = '0;
        fres.to_a = 1'b0;
        fres.wr  = r_item.rec;
        fres.ca  = r_ca;
        if (r_item.kind == K_MUL) begin
            fres.res = r_prod[63:32];
            fres.mq  = r_prod[31:0];
            ovf      = mul_ovf;
        end else if (r_item.op == OP_DIV) begin
            ovf = 1'b1;
            if (r_item.b == '0) begin
                fres.res = 32'h8000_0000;
                fres.mq  = '0;
            end else if (r_item.a == 32'h8000_0000 && r_mq == '0 &&
                         r_item.b == 32'hFFFF_FFFF) begin
                fres.res = '0;
                fres.mq  = '0;
            end else begin
                fres.res = q_s[31:0];
                fres.mq  = rem_s;
                ovf      = div_ovf;
            end
        end else begin
            ovf = 1'b1;
            if (r_item.b == '0) begin
                fres.res = 32'hFFFF_FFFF;
                fres.mq  = r_item.a;
            end else if (r_item.a == 32'h8000_0000 && r_item.b == 32'hFFFF_FFFF) begin
                fres.res = 32'h8000_0000;
                fres.mq  = '0;
            end else begin
                fres.res = q_s[31:0];
                fres.mq  = rem_s;
                ovf      = 1'b0;
            end
        end
        fres.crv = fres.mq;
        fres.ov  = r_item.oe ? ovf : r_ov;
        fres.so  = r_so | (r_item.oe && ovf);
    end

    assign sres = exec_simple(i_q_item, r_mq, r_so, r_ov, r_ca);
    assign ld   = (o_pop && i_q_item.kind == K_SIMPLE) || ((r_state == S_FIN) && out_free);
    assign ures = (r_state == S_FIN) ? fres : sres;

    always_comb begin
        cond = '0;
        if (ures.wr) begin
            cond[3] = ures.crv[31];
            cond[2] = !ures.crv[31] && (ures.crv != '0);
            cond[1] = (ures.crv == '0);
            cond[0] = ures.so;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && i_q_item.kind == K_MUL) begin
                    n_state = S_MUL;
                end else if (o_pop && i_q_item.kind == K_DIV) begin
                    n_state = S_DIV;
                end
            end
            S_MUL:   n_state = S_FIN;
            S_DIV:   n_state = (r_cnt == 6'd63) ? S_FIN : S_DIV;
            S_FIN:   n_state = out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mq     <= '0;
            r_so     <= 1'b0;
            r_ov     <= 1'b0;
            r_ca     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld) begin
                r_mq     <= ures.mq;
                r_so     <= ures.so;
                r_ov     <= ures.ov;
                r_ca     <= ures.ca;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (ld) begin
            r_odata <= {ures.mq, ures.ca, ures.ov, ures.so, ures.wr, cond, ures.res};
            r_odest <= ures.to_a;
        end
        if (o_pop) begin
            r_item <= i_q_item;
            r_sa   <= dvd[63];
            r_dq   <= dvd[63] ? (64'd0 - dvd) : dvd;
            r_dvs  <= i_q_item.b[31] ? (32'd0 - i_q_item.b) : i_q_item.b;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_state == S_DIV) begin
            r_rem <= ge ? 32'(trial - {1'b0, r_dvs}) : trial[31:0];
            r_dq  <= {r_dq[62:0], ge};
            r_cnt <= r_cnt + 6'd1;
        end
        if (r_state == S_MUL) begin
            r_prod <= 64'($signed(r_item.a) * $signed(r_item.b));
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_odest;

`ifndef SYNTHESIS
    a_mq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ld |=> $stable(r_mq))
        else $error("mq changed without a result");
    a_so_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_so |=> r_so)
        else $error("summary overflow cleared");
    a_busy_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("queue popped while busy");
    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> r_ovalid)
        else $error("finished result not loaded");
`endif

endmodule

// ----- hw/rtl/power_mq_fixed_point_unit.sv -----
// Legacy POWER integer unit with the MQ register and XER SO/OV/CA held inside.
// One operation per input word; each gives exactly one output word, in order.
// Abs, doz, mask, rotate and shift operations sustain one word per cycle while
// the output is not stalled and no mul or div is busy; they pass through the
// input register, a two-entry queue and the output register.
// mul passes through S_MUL, where the 32x32 product is registered, then S_FIN.
// div and divs run the radix-2 restoring divide loop of 64 steps in S_DIV,
// then S_FIN. An output register lets the next word be accepted while a
// result waits to be taken.
module power_mq_fixed_point_unit
    import pmq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // a[31:0] b[63:32] s[95:64] shift_imm[100:96] mask_begin[105:101]
    // mask_finish[110:106] signed_imm[126:111] record_flag[127]
    // overflow_enable[128] zero[135:129]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op_select[4:0]
    input  logic [4:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result_value[31:0] cond_field[35:32] cond_write[36] summary_overflow[37]
    // overflow_bit[38] carry_bit[39] mq_value[71:40]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // dest_is_a[0]
    output logic                  m_axis_tuser
);

    logic  push, q_ready, q_valid, pop;
    t_item f_item, q_item;

    pmq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (push),
        .o_item        (f_item),
        .i_q_ready     (q_ready)
    );

    pmq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    pmq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- dv/power_mq_fixed_point_unit_tb.sv -----
`timescale 1ns / 1ps

module power_mq_fixed_point_unit_tb;
    import pmq_pkg::*;

    typedef struct {
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] s;
        logic [4:0]  imm;
        logic [4:0]  mb;
        logic [4:0]  me;
        logic [15:0] simm;
        logic        rec;
        logic        oe;
    } t_instr;

    typedef struct packed {
        logic [31:0] res;
        logic        to_a;
        logic [3:0]  cr;
        logic        wr;
        logic        so;
        logic        ov;
        logic        ca;
        logic [31:0] mq;
    } t_outcome;

    typedef struct {
        t_instr   ins;
        logic     fixed;
        t_outcome want;
    } t_row;

    localparam int N_RANDOM = 1800;
    localparam int CYCLE_LIMIT = 1000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [4:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    logic [31:0] mq_q;
    logic        so_q;
    logic        ov_q;
    logic        ca_q;

    t_outcome    pending_results[$];
    int          n_errors;
    int          n_cycles;
    bit          no_idle;

    power_mq_fixed_point_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] rot_left(logic [31:0] v, logic [4:0] n);
        return (v << n) | (v >> (6'd32 - n));
    endfunction

    function automatic logic [31:0] rot_right(logic [31:0] v, logic [4:0] n);
        return (v >> n) | (v << (6'd32 - n));
    endfunction

    function automatic logic [31:0] field_mask(logic [4:0] mb, logic [4:0] me);
        logic [31:0] m1;
        logic [31:0] m2;
        m1 = 32'hFFFF_FFFF >> mb;
        m2 = 32'hFFFF_FFFF << (5'd31 - me);
        return (mb <= me) ? (m1 & m2) : (m1 | m2);
    endfunction

    function automatic logic [31:0] low_ones(logic [4:0] n);
        return (32'd1 << n) - 32'd1;
    endfunction

    task automatic set_ov(input logic en, input logic ovf);
        if (en) begin
            ov_q = ovf;
            if (ovf) so_q = 1'b1;
        end
    endtask

    task automatic execute_op(input t_instr t, output t_outcome o);
        logic [31:0] res;
        logic [31:0] crv;
        logic [31:0] m;
        logic [31:0] r;
        logic [31:0] simm;
        logic [4:0]  sh;
        logic [4:0]  st;
        logic        ext;
        logic        to_a;
        logic        wr;
        logic signed [63:0] dvd;
        logic signed [63:0] dvs;
        logic signed [63:0] q;
        logic signed [63:0] rm;
        logic signed [63:0] p;
        logic signed [31:0] x;
        logic signed [31:0] y;
        res = '0;
        crv = '0;
        to_a = 1'b1;
        wr = t.rec;
        sh = t.b[4:0];
        ext = t.b[5];
        simm = {{16{t.simm[15]}}, t.simm};
        case (t.op)
            OP_ABS: begin
                to_a = 1'b0;
                res = t.a[31] ? -t.a : t.a;
                set_ov(t.oe, t.a == 32'h8000_0000);
                crv = res;
            end
            OP_DIV: begin
                to_a = 1'b0;
                if (t.b == 0) begin
                    res = 32'h8000_0000;
                    crv = 0;
                    set_ov(t.oe, 1'b1);
                end else if ({t.a, mq_q} == 64'h8000_0000_0000_0000 && t.b == '1) begin
                    res = 0;
                    crv = 0;
                    set_ov(t.oe, 1'b1);
                end else begin
                    dvd = $signed({t.a, mq_q});
                    dvs = $signed({{32{t.b[31]}}, t.b});
                    q = dvd / dvs;
                    rm = dvd % dvs;
                    res = q[31:0];
                    crv = rm[31:0];
                    set_ov(t.oe, q < -64'sd2147483648 || q > 64'sd2147483647);
                end
                mq_q = crv;
            end
            OP_DIVS: begin
                to_a = 1'b0;
                if (t.b == 0) begin
                    res = '1;
                    crv = t.a;
                    set_ov(t.oe, 1'b1);
                end else if (t.a == 32'h8000_0000 && t.b == '1) begin
                    res = 32'h8000_0000;
                    crv = 0;
                    set_ov(t.oe, 1'b1);
                end else begin
                    x = t.a;
                    y = t.b;
                    res = x / y;
                    crv = x % y;
                    set_ov(t.oe, 1'b0);
                end
                mq_q = crv;
            end
            OP_DOZ: begin
                to_a = 1'b0;
                res = ($signed(t.a) < $signed(t.b)) ? t.b - t.a : 0;
                set_ov(t.oe, res[31]);
                crv = res;
            end
            OP_DOZI: begin
                to_a = 1'b0;
                wr = 1'b0;
                res = ($signed(t.a) > $signed(simm)) ? 0 : simm - t.a;
            end
            OP_MASKG: begin
                st = t.s[4:0];
                if ({1'b0, st} < {1'b0, sh} + 6'd1) res = field_mask(st, sh);
                else if ({1'b0, st} == {1'b0, sh} + 6'd1) res = '1;
                else res = ~field_mask(sh + 5'd1, st - 5'd1);
                crv = res;
            end
            OP_MASKIR: begin
                res = (t.a & ~t.b) | (t.s & t.b);
                crv = res;
            end
            OP_MUL: begin
                to_a = 1'b0;
                p = $signed(t.a) * $signed(t.b);
                res = p[63:32];
                mq_q = p[31:0];
                set_ov(t.oe, p < -64'sd2147483648 || p > 64'sd2147483647);
                crv = mq_q;
            end
            OP_NABS: begin
                to_a = 1'b0;
                res = t.a[31] ? t.a : -t.a;
                set_ov(t.oe, 1'b0);
                crv = res;
            end
            OP_RLMI: begin
                m = field_mask(t.mb, t.me);
                res = (rot_left(t.s, sh) & m) | (t.a & ~m);
                crv = res;
            end
            OP_RRIB: begin
                m = 32'h8000_0000 >> sh;
                res = t.s[31] ? (t.a | m) : (t.a & ~m);
                crv = res;
            end
            OP_SLE, OP_SLIQ: begin
                if (t.op == OP_SLIQ) sh = t.imm;
                res = t.s << sh;
                mq_q = rot_left(t.s, sh);
                crv = res;
            end
            OP_SLEQ, OP_SLLIQ: begin
                if (t.op == OP_SLLIQ) sh = t.imm;
                r = rot_left(t.s, sh);
                m = 32'hFFFF_FFFF << sh;
                res = (r & m) | (mq_q & ~m);
                mq_q = r;
                crv = res;
            end
            OP_SLLQ: begin
                if (ext) res = mq_q & (32'hFFFF_FFFF << sh);
                else res = (t.s << sh) | (mq_q & low_ones(sh));
                crv = res;
            end
            OP_SLQ: begin
                res = ext ? 0 : t.s << sh;
                mq_q = rot_left(t.s, sh);
                crv = res;
            end
            OP_SRAIQ: begin
                res = $signed(t.s) >>> t.imm;
                ca_q = t.s[31] && (t.s & low_ones(t.imm)) != 0;
                mq_q = rot_right(t.s, t.imm);
                crv = res;
            end
            OP_SRAQ: begin
                m = ext ? 32'hFFFF_FFFF : low_ones(sh);
                res = $signed(t.s) >>> (ext ? 5'd31 : sh);
                ca_q = t.s[31] && (t.s & m) != 0;
                mq_q = rot_right(t.s, sh);
                crv = res;
            end
            OP_SRE, OP_SRIQ: begin
                if (t.op == OP_SRIQ) sh = t.imm;
                res = t.s >> sh;
                mq_q = rot_right(t.s, sh);
                crv = res;
            end
            OP_SREA: begin
                r = rot_right(t.s, sh);
                m = 32'hFFFF_FFFF >> sh;
                res = $signed(t.s) >>> sh;
                ca_q = t.s[31] && (r & ~m) != 0;
                mq_q = r;
                crv = res;
            end
            OP_SREQ: begin
                m = 32'hFFFF_FFFF >> sh;
                res = (t.s >> sh) | (mq_q & ~m);
                mq_q = rot_right(t.s, sh);
                crv = res;
            end
            OP_SRLIQ: begin
                r = rot_right(t.s, t.imm);
                m = 32'hFFFF_FFFF >> t.imm;
                res = (r & m) | (mq_q & ~m);
                mq_q = r;
                crv = res;
            end
            OP_SRLQ: begin
                r = rot_right(t.s, sh);
                m = 32'hFFFF_FFFF >> sh;
                res = ext ? (mq_q & m) : ((r & m) | (mq_q & ~m));
                crv = res;
            end
            OP_SRQ: begin
                res = ext ? 0 : t.s >> sh;
                mq_q = rot_right(t.s, sh);
                crv = res;
            end
            default: begin
                to_a = 1'b0;
                wr = 1'b0;
                res = 0;
            end
        endcase
        o.res = res;
        o.to_a = to_a;
        o.wr = wr;
        o.cr = 4'd0;
        if (wr) o.cr = {crv[31], !crv[31] && crv != 0, crv == 0, so_q};
        o.so = so_q;
        o.ov = ov_q;
        o.ca = ca_q;
        o.mq = mq_q;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_errors++;
    endtask

    task automatic idle_burst(input int pct);
        if (!no_idle && $urandom_range(99) < pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(negedge i_clk);
        end
    endtask

    task automatic send_word(input t_instr t, input bit fixed, input t_outcome want);
        t_outcome o;
        idle_burst(15);
        execute_op(t, o);
        if (fixed && o != want) report_mismatch("table row", o.res, want.res);
        s_axis_tdata <= {7'd0, t.oe, t.rec, t.simm, t.me, t.mb, t.imm, t.s, t.b, t.a};
        s_axis_tuser <= t.op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(o);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(63);
            4: return -$urandom_range(63);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_instr random_instr();
        t_instr t;
        t.op = $urandom_range(99) < 3 ? t_op'($urandom_range(31, 26)) : t_op'($urandom_range(25));
        t.a = pick_word();
        t.b = pick_word();
        t.s = pick_word();
        t.imm = 5'($urandom);
        t.mb = 5'($urandom);
        t.me = 5'($urandom);
        t.simm = $urandom_range(3) == 0 ? 16'(pick_word()) : 16'($urandom);
        t.rec = 1'($urandom);
        t.oe = 1'($urandom);
        if (t.op == OP_DIV && $urandom_range(3) == 0) t.a = {32{mq_q[31]}} ^ $urandom_range(3);
        return t;
    endfunction

    // output side: stall bursts and compare
    initial begin
        t_outcome w;
        t_outcome g;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(99) < 12) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(11, 1)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                g.res = m_axis_tdata[31:0];
                g.cr = m_axis_tdata[35:32];
                g.wr = m_axis_tdata[36];
                g.so = m_axis_tdata[37];
                g.ov = m_axis_tdata[38];
                g.ca = m_axis_tdata[39];
                g.mq = m_axis_tdata[71:40];
                g.to_a = m_axis_tuser;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", g.res, 32'd0);
                end else begin
                    w = pending_results.pop_front();
                    if (g.res !== w.res) report_mismatch("result", g.res, w.res);
                    if (g.to_a !== w.to_a) report_mismatch("dest", g.to_a, w.to_a);
                    if (g.cr !== w.cr) report_mismatch("cr0", g.cr, w.cr);
                    if (g.wr !== w.wr) report_mismatch("cr write", g.wr, w.wr);
                    if (g.so !== w.so) report_mismatch("so", g.so, w.so);
                    if (g.ov !== w.ov) report_mismatch("ov", g.ov, w.ov);
                    if (g.ca !== w.ca) report_mismatch("ca", g.ca, w.ca);
                    if (g.mq !== w.mq) report_mismatch("mq", g.mq, w.mq);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_row     rows[$];
        t_row     row;
        t_outcome z;
        t_instr   t;
        n_errors = 0;
        no_idle = 1'b0;
        mq_q = 0;
        so_q = 0;
        ov_q = 0;
        ca_q = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        z = '{res: 0, to_a: 0, cr: 0, wr: 0, so: 0, ov: 0, ca: 0, mq: 0};
        t = '{op: OP_ABS, a: 32'h8000_0000, b: 0, s: 0, imm: 0, mb: 0, me: 0,
              simm: 0, rec: 1, oe: 1};
        // abs of most negative overflows
        row.ins = t;
        row.fixed = 1;
        row.want = '{res: 32'h8000_0000, to_a: 0, cr: 4'b1001, wr: 1, so: 1, ov: 1,
                     ca: 0, mq: 0};
        rows.push_back(row);
        // divide by zero
        t.op = OP_DIV; t.a = 32'd5;
        row.ins = t;
        row.want = '{res: 32'h8000_0000, to_a: 0, cr: 4'b0011, wr: 1, so: 1, ov: 1,
                     ca: 0, mq: 0};
        rows.push_back(row);
        t.op = OP_DIVS; t.a = 32'd7;
        row.ins = t;
        row.want = '{res: 32'hFFFF_FFFF, to_a: 0, cr: 4'b0101, wr: 1, so: 1, ov: 1,
                     ca: 0, mq: 7};
        rows.push_back(row);
        row.fixed = 0;
        // divs of most negative by minus one
        t.op = OP_DIVS; t.a = 32'h8000_0000; t.b = '1; row.ins = t; rows.push_back(row);
        // mq to zero, then div of -2^63 by -1
        t.op = OP_MUL; t.a = 0; t.b = 0; row.ins = t; rows.push_back(row);
        t.op = OP_DIV; t.a = 32'h8000_0000; t.b = '1; row.ins = t; rows.push_back(row);
        t.op = OP_DIV; t.a = 32'h0000_0001; t.b = 32'd2; row.ins = t; rows.push_back(row);
        t.op = OP_MUL; t.a = 32'h8000_0000; t.b = 32'h8000_0000; row.ins = t;
        rows.push_back(row);
        for (int k = 0; k <= 31; k++) begin
            t.op = t_op'(k);
            t.a = k[0] ? 32'hFFFF_FFFF : 32'h8000_0001;
            t.b = k[1] ? 32'h0000_003F : 32'h0000_0021;
            t.s = k[2] ? 32'hFFFF_FFFF : 32'h8000_0000;
            t.imm = k[3] ? 5'd31 : 5'd0;
            t.mb = k[4] ? 5'd31 : 5'd0;
            t.me = k[0] ? 5'd0 : 5'd31;
            t.simm = k[1] ? 16'h8000 : 16'h7FFF;
            t.rec = !k[0];
            t.oe = k[2];
            if (k < 26 || k == 31) begin
                row.ins = t;
                rows.push_back(row);
            end
        end
        foreach (rows[i]) send_word(rows[i].ins, rows[i].fixed, rows[i].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                s_axis_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge i_clk);
            end
            if (n == N_RANDOM - 200) no_idle = 1'b1;
            send_word(random_instr(), 0, z);
        end
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(negedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
